// ===== rtl/record_quicksort_explicit_stack_top_defines.svh =====
// ---------------------------------------------------------------------------
// record sorter assertion macros
// concurrent check wrappers, clocked on clock and masked during reset
// ---------------------------------------------------------------------------
`ifndef RECORD_QUICKSORT_EXPLICIT_STACK_TOP_DEFINES_SVH
`define RECORD_QUICKSORT_EXPLICIT_STACK_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define RQS_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("rqs check failed");

// condition must never be seen outside reset
`define RQS_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("rqs forbidden condition");

`else

`define RQS_ASSERT(lbl, prop)
`define RQS_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/rqs_pkg.sv =====
// ---------------------------------------------------------------------------
// record sorter package
// field widths and sequencer state codes
// ---------------------------------------------------------------------------
package rqs_pkg;

   localparam int KEY_W = 16;
   localparam int TAG_W = 16;

   typedef logic [3:0] state_type;

   localparam state_type ST_IDLE     = 4'd0;
   localparam state_type ST_LOOP     = 4'd1;
   localparam state_type ST_PIVOT    = 4'd2;
   localparam state_type ST_IREAD    = 4'd3;
   localparam state_type ST_ICMP     = 4'd4;
   localparam state_type ST_JREAD    = 4'd5;
   localparam state_type ST_JCMP     = 4'd6;
   localparam state_type ST_SWAP_A   = 4'd7;
   localparam state_type ST_SWAP_B   = 4'd8;
   localparam state_type ST_PART_END = 4'd9;
   localparam state_type ST_POP      = 4'd10;
   localparam state_type ST_OUT_RD   = 4'd11;
   localparam state_type ST_OUT_LD   = 4'd12;
   localparam state_type ST_OUT_SEND = 4'd13;

endpackage

// ===== rtl/rqs_req_if.sv =====
// ---------------------------------------------------------------------------
// record sorter request channel
// valid/ready channel carrying one unsorted record
// ---------------------------------------------------------------------------
interface rqs_req_if import rqs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] page_key;
   logic [TAG_W-1:0] record_tag;
   logic             last_record;

   modport source (output valid, page_key, record_tag, last_record, input ready);
   modport sink   (input valid, page_key, record_tag, last_record, output ready);
endinterface

// ===== rtl/rqs_rsp_if.sv =====
// ---------------------------------------------------------------------------
// record sorter response channel
// valid/ready channel carrying one sorted record
// ---------------------------------------------------------------------------
interface rqs_rsp_if import rqs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic [TAG_W-1:0] sorted_tag;
   logic             final_out;

   modport source (output valid, sorted_key, sorted_tag, final_out, input ready);
   modport sink   (input valid, sorted_key, sorted_tag, final_out, output ready);
endinterface

// ===== rtl/rqs_ram.sv =====
// ---------------------------------------------------------------------------
// record sorter generic ram
// one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module rqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/record_quicksort_explicit_stack_top.sv =====
// ---------------------------------------------------------------------------
// record sorter top level
// non-recursive quicksort of keyed records with hoare partition
// ---------------------------------------------------------------------------
// usage
//  - req_chan takes one record per transaction (key, tag, last flag); while
//    idle one record is stored per cycle, records past MAX_RECORDS are dropped
//  - a record flagged last starts the sort; req_chan.ready stays low until
//    the whole sorted run has left on rsp_chan
//  - sort time is data dependent: per partition a range check, pivot read,
//    a read and compare per step of either scan (the compare that stops a
//    scan included), a write per record swapped and a split; a closing range
//    is checked and popped; all set by the single ram read and write port
//  - output: per record a ram read, a load and a send, plus any wait while the
//    receiver holds rsp_chan.ready low; the result register simply holds its
//    transaction until taken, final_out marks the last record of the run
//  - the record ram has no reset; only control state is cleared
//  - reset (synchronous, active high) empties the store and the range stack
//    and returns the sequencer to idle; no clearing pass is needed
// ---------------------------------------------------------------------------
`include "record_quicksort_explicit_stack_top_defines.svh"

module record_quicksort_explicit_stack_top import rqs_pkg::*; #(
   parameter int MAX_RECORDS = 64,
   parameter int STACK_DEPTH = 8,
   parameter int KEY_BITS    = 16
) (
   input  logic     clock,
   input  logic     reset,
   rqs_req_if.sink  req_chan,
   rqs_rsp_if.source rsp_chan
);
   // widths derived from the parameters
   localparam int IW  = $clog2(MAX_RECORDS);         // record address
   localparam int CW  = $clog2(MAX_RECORDS + 1);     // record count
   localparam int PW  = CW + 1;                      // signed scan index
   localparam int DW  = PW + 1;                      // index differences
   localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
   localparam int RW  = KW + TAG_W;                  // ram word: key, tag
   localparam int SW  = $clog2(STACK_DEPTH + 1);     // stack level
   localparam int SIW = $clog2(STACK_DEPTH);         // stack index

   // sequencer state
   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] k_ff, k_in;
   logic signed [PW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [PW-1:0] i_ff, i_in, j_ff, j_in;
   logic [KW-1:0] pivot_ff, pivot_in;
   logic [RW-1:0] rec_i_ff, rec_i_in, rec_j_ff, rec_j_in;
   logic [SW-1:0] level_ff, level_in;

   // range stack, read only at its top
   logic [IW-1:0] stack_lo_ff [STACK_DEPTH];
   logic [IW-1:0] stack_hi_ff [STACK_DEPTH];
   logic          push_en;
   logic [IW-1:0] push_lo, push_hi;
   logic [SIW-1:0] push_idx, pop_idx;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [TAG_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic             rsp_final_ff, rsp_final_in;
   logic             run_done;

   // record ram control
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [RW-1:0] wr_data, rd_data;
   logic [KW-1:0] rd_key;

   // shared index arithmetic
   logic signed [DW-1:0] mid_sum, diff_left, diff_right;
   logic [CW-1:0] n_next;
   logic          req_take;

   rqs_ram #(
      .WIDTH (RW),
      .DEPTH (MAX_RECORDS)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key     = rd_data[RW-1:TAG_W];
   assign mid_sum    = DW'(lo_ff) + DW'(hi_ff);
   assign diff_left  = DW'(j_ff) - DW'(lo_ff);
   assign diff_right = DW'(hi_ff) - DW'(i_ff);
   assign req_take   = req_chan.valid && (state_ff == ST_IDLE);
   assign pop_idx    = SIW'(level_ff - SW'(1));
   assign push_idx   = SIW'(level_ff);
   assign run_done   = rsp_valid_ff && rsp_chan.ready && rsp_final_ff;

   // count after the current transaction is stored (store full drops it)
   assign n_next = (count_ff < CW'(MAX_RECORDS)) ? count_ff + CW'(1) : count_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pivot_in     = pivot_ff;
      rec_i_in     = rec_i_ff;
      rec_j_in     = rec_j_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_final_in = rsp_final_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IW-1:0];
      wr_data      = {req_chan.page_key[KW-1:0], req_chan.record_tag};
      rd_addr      = i_ff[IW-1:0];
      push_en      = 1'b0;
      push_lo      = i_ff[IW-1:0];
      push_hi      = hi_ff[IW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wr_en    = (count_ff < CW'(MAX_RECORDS));
               count_in = n_next;
               if (req_chan.last_record) begin
                  // whole store is the first range
                  lo_in    = '0;
                  hi_in    = $signed({1'b0, n_next}) - PW'(1);
                  level_in = '0;
                  state_in = ST_LOOP;
               end
            end
         end
         ST_LOOP: begin
            if (lo_ff < hi_ff) begin
               i_in     = lo_ff;
               j_in     = hi_ff;
               rd_addr  = mid_sum[IW:1];
               state_in = ST_PIVOT;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_PIVOT: begin
            pivot_in = rd_key;
            state_in = ST_IREAD;
         end
         ST_IREAD: begin
            rd_addr  = i_ff[IW-1:0];
            state_in = ST_ICMP;
         end
         ST_ICMP: begin
            if ((i_ff < hi_ff) && (rd_key < pivot_ff)) begin
               i_in     = i_ff + PW'(1);
               state_in = ST_IREAD;
            end else begin
               rec_i_in = rd_data;
               state_in = ST_JREAD;
            end
         end
         ST_JREAD: begin
            rd_addr  = j_ff[IW-1:0];
            state_in = ST_JCMP;
         end
         ST_JCMP: begin
            if ((j_ff > lo_ff) && (rd_key > pivot_ff)) begin
               j_in     = j_ff - PW'(1);
               state_in = ST_JREAD;
            end else begin
               rec_j_in = rd_data;
               state_in = (i_ff <= j_ff) ? ST_SWAP_A : ST_PART_END;
            end
         end
         ST_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = i_ff[IW-1:0];
            wr_data  = rec_j_ff;
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff[IW-1:0];
            wr_data  = rec_i_ff;
            i_in     = i_ff + PW'(1);
            j_in     = j_ff - PW'(1);
            // next pass of the partition loop uses the updated indexes
            state_in = ((i_ff + PW'(1)) <= (j_ff - PW'(1))) ? ST_IREAD : ST_PART_END;
         end
         ST_PART_END: begin
            // keep the smaller side, push the larger one if it holds more than one record and the stack has room
            if (diff_left < diff_right) begin
               push_en = (i_ff < hi_ff) && (level_ff < SW'(STACK_DEPTH));
               push_lo = i_ff[IW-1:0];
               push_hi = hi_ff[IW-1:0];
               hi_in   = j_ff;
            end else begin
               push_en = (lo_ff < j_ff) && (level_ff < SW'(STACK_DEPTH));
               push_lo = lo_ff[IW-1:0];
               push_hi = j_ff[IW-1:0];
               lo_in   = i_ff;
            end
            if (push_en) begin
               level_in = level_ff + SW'(1);
            end
            state_in = ST_LOOP;
         end
         ST_POP: begin
            if (level_ff == '0) begin
               k_in     = '0;
               state_in = ST_OUT_RD;
            end else begin
               level_in = level_ff - SW'(1);
               lo_in    = $signed(PW'(stack_lo_ff[pop_idx]));
               hi_in    = $signed(PW'(stack_hi_ff[pop_idx]));
               state_in = ST_LOOP;
            end
         end
         ST_OUT_RD: begin
            rd_addr  = k_ff[IW-1:0];
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_key_in   = KEY_W'(rd_key);
            rsp_tag_in   = rd_data[TAG_W-1:0];
            rsp_final_in = (k_ff == count_ff - CW'(1));
            state_in     = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  count_in = '0;
                  level_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pivot_ff     <= pivot_in;
      rec_i_ff     <= rec_i_in;
      rec_j_ff     <= rec_j_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_final_ff <= rsp_final_in;
   end

   // range stack write
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_lo_ff[push_idx] <= push_lo;
         stack_hi_ff[push_idx] <= push_hi;
      end
   end

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sorted_key = rsp_key_ff;
   assign rsp_chan.sorted_tag = rsp_tag_ff;
   assign rsp_chan.final_out  = rsp_final_ff;

   // no new record is taken while a sorted record is still pending
   `RQS_NEVER(a_no_take_during_output, req_take && rsp_valid_ff)
   // the scans have crossed when a partition closes
   `RQS_ASSERT(a_scans_crossed, (state_ff == ST_PART_END) |-> (i_ff > j_ff))
   // the left scan stays within its range
   `RQS_ASSERT(a_i_bounds, (state_ff == ST_ICMP) |-> ((i_ff >= lo_ff) && (i_ff <= hi_ff)))
   // the last record of a run empties the store
   `RQS_ASSERT(a_run_end, run_done |=> ((state_ff == ST_IDLE) && (count_ff == '0)))
   // the range stack never overflows
   `RQS_NEVER(a_stack_overflow, level_ff > SW'(STACK_DEPTH))
endmodule
